>>> hw/rtl/srs_pkg.sv
`timescale 1ns / 1ps

package srs_pkg;

  localparam int SEQ_SPACE    = 8;
  localparam int WINDOW_SLOTS = 4;

  localparam int SEQ_W  = $clog2(SEQ_SPACE);
  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int OFF_W  = 9;

  localparam int OP_W      = 2;
  localparam int PAYLOAD_W = 64;
  localparam int NUM_W     = 8;
  localparam int ACTION_W  = 3;

  localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_IGNORED  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REFUSED  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TRANSMIT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_START    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_STOP     = 3'd4;

  typedef struct packed {
    logic load;
    logic eval;
    logic slide;
    logic second;
  } srs_cmd_t;

  typedef struct packed {
    logic slide_needed;
    logic slide_more;
    logic more_results;
  } srs_sts_t;

endpackage

>>> hw/rtl/srs_if.sv
`timescale 1ns / 1ps

interface srs_in_if;
  logic                           valid;
  logic                           ready;
  logic [srs_pkg::OP_W-1:0]       operation;
  logic [srs_pkg::PAYLOAD_W-1:0]  payload_word;
  logic [srs_pkg::NUM_W-1:0]      ack_number;
  logic                           ack_checksum_ok;
  logic [srs_pkg::NUM_W-1:0]      expired_seq;

  modport source (output valid, operation, payload_word, ack_number, ack_checksum_ok,
                  expired_seq, input ready);
  modport sink (input valid, operation, payload_word, ack_number, ack_checksum_ok,
                expired_seq, output ready);
endinterface

interface srs_out_if;
  logic                           valid;
  logic                           ready;
  logic [srs_pkg::ACTION_W-1:0]   action;
  logic [srs_pkg::NUM_W-1:0]      seq_out;
  logic [srs_pkg::PAYLOAD_W-1:0]  payload_out;
  logic                           window_full;
  logic [srs_pkg::NUM_W-1:0]      window_base;
  logic                           last;

  modport source (output valid, action, seq_out, payload_out, window_full, window_base,
                  last, input ready);
  modport sink (input valid, action, seq_out, payload_out, window_full, window_base,
                last, output ready);
endinterface

>>> hw/rtl/selective_repeat_sender_unit.sv
`timescale 1ns / 1ps
// Sequence: accept an item, decide in S_EVAL, then give the first result; an ack at
// the window base first walks the base past every acked slot in S_SLIDE. A transmit
// gives a second result (start timer) after the first. The single-item controller
// takes no new item until the last result of the current one has been taken, and a
// stall on the output holds it.
// Reset (rst, synchronous): window empty, base and next sequence one, no acked slots.

module selective_repeat_sender_unit (
  input logic clk,
  input logic rst,
  srs_in_if.sink    in_ch,
  srs_out_if.source out_ch
);
  import srs_pkg::*;

  srs_cmd_t cmd;
  srs_sts_t sts;

  srs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srs_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .operation       (in_ch.operation),
    .payload_word    (in_ch.payload_word),
    .ack_number      (in_ch.ack_number),
    .ack_checksum_ok (in_ch.ack_checksum_ok),
    .expired_seq     (in_ch.expired_seq),
    .action          (out_ch.action),
    .seq_out         (out_ch.seq_out),
    .payload_out     (out_ch.payload_out),
    .window_full     (out_ch.window_full),
    .window_base     (out_ch.window_base),
    .last            (out_ch.last)
  );

endmodule

>>> hw/rtl/srs_ctrl.sv
`timescale 1ns / 1ps

module srs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  srs_pkg::srs_sts_t sts,
  output srs_pkg::srs_cmd_t cmd
);
  import srs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SLIDE,
    S_EMIT1,
    S_EMIT2
  } state_t;

  state_t state, state_next;
  logic   out_xfer;

  assign out_xfer = out_valid && out_ready;

  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid && in_ready;
    cmd.eval   = (state == S_EVAL);
    cmd.slide  = (state == S_SLIDE) && sts.slide_more;
    cmd.second = (state == S_EMIT1) && out_xfer && sts.more_results;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid && in_ready) state_next = S_EVAL;
      S_EVAL:  state_next = sts.slide_needed ? S_SLIDE : S_EMIT1;
      // walk one acked slot per cycle
      S_SLIDE: if (!sts.slide_more) state_next = S_EMIT1;
      S_EMIT1: begin
        if (out_xfer) state_next = sts.more_results ? S_EMIT2 : S_IDLE;
      end
      S_EMIT2: if (out_xfer) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= (state_next == S_EMIT1) || (state_next == S_EMIT2);
    end
  end

endmodule

>>> hw/rtl/srs_datapath.sv
`timescale 1ns / 1ps

module srs_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  srs_pkg::srs_cmd_t                cmd,
  output srs_pkg::srs_sts_t                sts,
  input  logic [srs_pkg::OP_W-1:0]         operation,
  input  logic [srs_pkg::PAYLOAD_W-1:0]    payload_word,
  input  logic [srs_pkg::NUM_W-1:0]        ack_number,
  input  logic                             ack_checksum_ok,
  input  logic [srs_pkg::NUM_W-1:0]        expired_seq,
  output logic [srs_pkg::ACTION_W-1:0]     action,
  output logic [srs_pkg::NUM_W-1:0]        seq_out,
  output logic [srs_pkg::PAYLOAD_W-1:0]    payload_out,
  output logic                             window_full,
  output logic [srs_pkg::NUM_W-1:0]        window_base,
  output logic                             last
);
  import srs_pkg::*;

  // latched item
  logic [OP_W-1:0]      item_op;
  logic [PAYLOAD_W-1:0] item_payload;
  logic [NUM_W-1:0]     item_ack;
  logic                 item_ok;
  logic [NUM_W-1:0]     item_exp;

  // window state
  logic [PAYLOAD_W-1:0]    slot_payload [WINDOW_SLOTS];
  logic [WINDOW_SLOTS-1:0] slot_acked;
  logic [SLOT_W-1:0]       ring_head;
  logic [CNT_W-1:0]        outstanding_count;
  logic [SEQ_W-1:0]        base_seq;
  logic [SEQ_W-1:0]        next_seq;

  // decision for the latched item
  logic [ACTION_W-1:0] d_action;
  logic [NUM_W-1:0]    d_seq;
  logic                d_two;
  logic                d_store;
  logic                d_mark;
  logic                d_slide;
  logic                d_from_mem;
  logic [NUM_W-1:0]    probe;
  logic [OFF_W-1:0]    probe_off;
  logic                probe_in_win;
  logic [SLOT_W-1:0]   probe_slot;
  logic [SLOT_W-1:0]   tail_slot;
  logic                full;

  function automatic logic [SLOT_W-1:0] ring_slot(logic [SLOT_W-1:0] h, logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(k);
    if (s >= SUM_W'(WINDOW_SLOTS)) s = s - SUM_W'(WINDOW_SLOTS);
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] seq_inc(logic [SEQ_W-1:0] s);
    return (s == SEQ_W'(SEQ_SPACE - 1)) ? '0 : s + 1'b1;
  endfunction

  assign full = (outstanding_count >= CNT_W'(WINDOW_SLOTS));

  always_comb begin
    probe = (item_op == OP_ACK) ? item_ack : item_exp;
    if (probe >= NUM_W'(base_seq)) begin
      probe_off = OFF_W'(probe) - OFF_W'(base_seq);
    end else begin
      probe_off = OFF_W'(probe) + OFF_W'(SEQ_SPACE) - OFF_W'(base_seq);
    end
    probe_in_win = (OFF_W'(probe) < OFF_W'(SEQ_SPACE)) &&
                   (probe_off < OFF_W'(outstanding_count));
    probe_slot   = ring_slot(ring_head, probe_off[CNT_W-1:0]);
    tail_slot    = ring_slot(ring_head, outstanding_count);
  end

  always_comb begin
    d_action   = ACT_IGNORED;
    d_seq      = '0;
    d_two      = 1'b0;
    d_store    = 1'b0;
    d_mark     = 1'b0;
    d_slide    = 1'b0;
    d_from_mem = 1'b0;
    unique case (item_op)
      OP_SEND: begin
        d_seq = NUM_W'(next_seq);
        if (full) begin
          d_action = ACT_REFUSED;
        end else begin
          d_action = ACT_TRANSMIT;
          d_two    = 1'b1;
          d_store  = 1'b1;
        end
      end
      OP_ACK: begin
        d_seq = item_ack;
        if (item_ok && probe_in_win) begin
          d_action = ACT_STOP;
          d_mark   = 1'b1;
          d_slide  = (probe_off == '0);
        end
      end
      OP_TIMEOUT: begin
        d_seq = item_exp;
        if (probe_in_win && !slot_acked[probe_slot]) begin
          d_action   = ACT_TRANSMIT;
          d_two      = 1'b1;
          d_from_mem = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign sts.slide_needed = d_slide;
  assign sts.slide_more   = (outstanding_count != '0) && slot_acked[ring_head];
  assign sts.more_results = !last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op      <= operation;
      item_payload <= payload_word;
      item_ack     <= ack_number;
      item_ok      <= ack_checksum_ok;
      item_exp     <= expired_seq;
    end
  end

  // payload store and result registers
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (d_store) slot_payload[tail_slot] <= item_payload;
      action  <= d_action;
      seq_out <= d_seq;
      last    <= !d_two;
      if (d_from_mem) begin
        payload_out <= slot_payload[probe_slot];
      end else if (d_store) begin
        payload_out <= item_payload;
      end else begin
        payload_out <= '0;
      end
    end else if (cmd.second) begin
      action      <= ACT_START;
      payload_out <= '0;
      last        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_acked        <= '0;
      ring_head         <= '0;
      outstanding_count <= '0;
      base_seq          <= SEQ_W'(1 % SEQ_SPACE);
      next_seq          <= SEQ_W'(1 % SEQ_SPACE);
    end else if (cmd.eval) begin
      if (d_store) begin
        slot_acked[tail_slot] <= 1'b0;
        outstanding_count     <= outstanding_count + 1'b1;
        next_seq              <= seq_inc(next_seq);
      end
      if (d_mark) slot_acked[probe_slot] <= 1'b1;
    end else if (cmd.slide) begin
      slot_acked[ring_head] <= 1'b0;
      ring_head             <= ring_slot(ring_head, CNT_W'(1));
      base_seq              <= seq_inc(base_seq);
      outstanding_count     <= outstanding_count - 1'b1;
    end
  end

  assign window_full = full;
  assign window_base = NUM_W'(base_seq);

endmodule

>>> hw/rtl/srs_checker.sv
`timescale 1ns / 1ps

module srs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [srs_pkg::ACTION_W-1:0]     action,
  input logic [srs_pkg::NUM_W-1:0]        seq_out,
  input logic [srs_pkg::PAYLOAD_W-1:0]    payload_out,
  input logic                             window_full,
  input logic                             last
);
  import srs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(seq_out) &&
      $stable(last))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_start_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && action == ACT_TRANSMIT && !last |=>
      out_valid && action == ACT_START && last && seq_out == $past(seq_out))
    else $error("transmit not followed by start timer");

  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_REFUSED |-> window_full && last)
    else $error("refusal without full window");

  a_stop_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_STOP |-> last && payload_out == '0)
    else $error("stop timer result malformed");

endmodule

bind selective_repeat_sender_unit srs_checker u_srs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .action      (out_ch.action),
  .seq_out     (out_ch.seq_out),
  .payload_out (out_ch.payload_out),
  .window_full (out_ch.window_full),
  .last        (out_ch.last)
);
